// ----- design/cqr_pkg.sv -----
// Package for the circular queue with reverse unit.
// Holds the item types, request and status codes, controller states and the
// command and status structs shared by the controller, datapath and top level.
package cqr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W = 5;
  localparam int DATA_W = 32;
  localparam int CNT_W = 5;
  localparam int IDX_W = 4;
  localparam int PADDR_W = 1;
  localparam int PDATA_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [PADDR_W-1:0] REG_CAP_ADDR = 1'b0;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_REV  = 2'd2,
    REQ_DUMP = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    req_e                     req_type;
    logic signed [DATA_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;
    logic [IDX_W-1:0]         head_index;
    logic [IDX_W-1:0]         tail_index;
    logic                     last;
  } rsp_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DEQ_WAIT,
    S_SWAP_RA,
    S_SWAP_RB,
    S_SWAP_WA,
    S_SWAP_WB,
    S_REV_DONE,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ENQ,
    OP_EMIT,
    OP_DEQ_RD,
    OP_DEQ_DONE,
    OP_REV_START,
    OP_RD_A,
    OP_RD_B,
    OP_WR_A,
    OP_WR_B,
    OP_DUMP_START,
    OP_DUMP_RD,
    OP_DUMP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic    load;
    dp_op_e  op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    req_e req_type;
    logic empty;
    logic full;
    logic few;
    logic rem_one;
    logic out_free;
  } stat_t;

endpackage

// ----- design/circular_queue_with_reverse_unit.sv -----
// Top level of the circular queue with reverse unit: APB register port,
// controller and datapath. Depends on cqr_pkg, cqr_ctrl and cqr_dp.
//
// A ring-buffer queue of signed 32-bit words whose usable capacity is set by
// the capacity register (byte address 0; 0 acts as 1, values above DEPTH act
// as DEPTH; reset value 16). Writing the register also empties the queue.
// Each request enqueues, dequeues, reverses the held entries in place, or
// dumps them front to back, one result per entry with last set on the final
// one. Every result carries the fill count and head and tail slots as they
// stand after the request. The block works on one request at a time. A
// reverse swaps entry pairs from both ends inward, with one slot memory port
// each for reading and writing, so each swap is two reads and two writes. A
// dump does one memory read per emitted entry. A result waiting in the
// output register does not block the next request from being accepted; only
// its own emit waits.
module circular_queue_with_reverse_unit #(
  parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cqr_pkg::PADDR_W-1:0] paddr,
  input  logic [cqr_pkg::PDATA_W-1:0] pwdata,
  output logic [cqr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  cqr_pkg::req_item_t          req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output cqr_pkg::rsp_item_t          rsp
);
  import cqr_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic              cfg_we;
  logic [CAP_W-1:0]  cap_raw;

  // The register port never waits; a write lands in the access phase.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == REG_CAP_ADDR);
  assign prdata = (paddr == REG_CAP_ADDR) ? PDATA_W'(cap_raw) : '0;

  cqr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata[CAP_W-1:0]),
    .cap_raw   (cap_raw),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- design/cqr_ctrl.sv -----
// Controller state machine of the circular queue with reverse unit.
// Sequences each request into datapath operations; depends on cqr_pkg.
module cqr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cqr_pkg::stat_t stat,
  output cqr_pkg::cmd_t  cmd
);
  import cqr_pkg::*;

  state_e state;
  state_e state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load = 1'b0;
    cmd.op = OP_NONE;
    cmd.status = ST_OK;
    req_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req_type)
          REQ_ENQ: begin
            if (stat.out_free) begin
              if (stat.full) begin
                cmd.op = OP_EMIT;
                cmd.status = ST_FULL;
              end else begin
                cmd.op = OP_ENQ;
              end
              state_next = S_IDLE;
            end
          end
          REQ_DEQ: begin
            if (!stat.empty) begin
              cmd.op = OP_DEQ_RD;
              state_next = S_DEQ_WAIT;
            end else if (stat.out_free) begin
              cmd.op = OP_EMIT;
              cmd.status = ST_EMPTY;
              state_next = S_IDLE;
            end
          end
          REQ_REV: begin
            if (!stat.few) begin
              cmd.op = OP_REV_START;
              state_next = S_SWAP_RA;
            end else if (stat.out_free) begin
              cmd.op = OP_EMIT;
              state_next = S_IDLE;
            end
          end
          REQ_DUMP: begin
            if (!stat.empty) begin
              cmd.op = OP_DUMP_START;
              state_next = S_DUMP_RD;
            end else if (stat.out_free) begin
              cmd.op = OP_EMIT;
              cmd.status = ST_EMPTY;
              state_next = S_IDLE;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_DEQ_WAIT: begin
        if (stat.out_free) begin
          cmd.op = OP_DEQ_DONE;
          state_next = S_IDLE;
        end
      end
      S_SWAP_RA: begin
        cmd.op = OP_RD_A;
        state_next = S_SWAP_RB;
      end
      S_SWAP_RB: begin
        cmd.op = OP_RD_B;
        state_next = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd.op = OP_WR_A;
        state_next = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        cmd.op = OP_WR_B;
        state_next = stat.rem_one ? S_REV_DONE : S_SWAP_RA;
      end
      S_REV_DONE: begin
        if (stat.out_free) begin
          cmd.op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd.op = OP_DUMP_RD;
        state_next = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (stat.out_free) begin
          cmd.op = OP_DUMP_EMIT;
          state_next = stat.rem_one ? S_IDLE : S_DUMP_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/cqr_dp.sv -----
// Datapath of the circular queue with reverse unit: slot memory, ring
// pointers, fill count, capacity register and the result register.
// Depends on cqr_pkg.
module cqr_dp #(
  parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cqr_pkg::req_item_t        req,
  input  cqr_pkg::cmd_t             cmd,
  output cqr_pkg::stat_t            stat,
  input  logic                      cfg_we,
  input  logic [cqr_pkg::CAP_W-1:0] cfg_wdata,
  output logic [cqr_pkg::CAP_W-1:0] cap_raw,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output cqr_pkg::rsp_item_t        rsp
);
  import cqr_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;

  logic [DATA_W-1:0] mem [DEPTH];

  req_item_t         req_r;
  logic [PW-1:0]     head, head_next;
  logic [PW-1:0]     tail, tail_next;
  logic [FW-1:0]     fill, fill_next;
  logic [PW-1:0]     pa, pa_next;
  logic [PW-1:0]     pb, pb_next;
  logic [FW-1:0]     rem, rem_next;
  logic [DATA_W-1:0] hold, hold_next;
  logic [DATA_W-1:0] rd_data;

  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [PW-1:0]     mem_raddr;

  logic [CMPW-1:0]   cap_ext;
  logic [CMPW-1:0]   cap_clamp;
  logic [FW-1:0]     cap;
  logic              out_free;
  logic              emit;
  status_e           emit_status;
  logic [DATA_W-1:0] emit_data;
  logic              emit_last;

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p,
                                             input logic [FW-1:0] c);
    if (FW'(p) + FW'(1) == c) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_dec(input logic [PW-1:0] p,
                                             input logic [FW-1:0] c);
    if (p == '0) begin
      return PW'(c - FW'(1));
    end
    return p - PW'(1);
  endfunction

  // A capacity of zero acts as one, anything above the built depth as the depth.
  assign cap_ext = CMPW'(cap_raw);
  assign cap_clamp = (cap_ext == '0) ? CMPW'(1) :
                     (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
  assign cap = FW'(cap_clamp);

  assign out_free = !rsp_valid || !rsp_stall;

  assign stat.req_type = req_r.req_type;
  assign stat.empty = (fill == '0);
  assign stat.full = (fill >= cap);
  assign stat.few = (fill < FW'(2));
  assign stat.rem_one = (rem == FW'(1));
  assign stat.out_free = out_free;

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    pa_next = pa;
    pb_next = pb;
    rem_next = rem;
    hold_next = hold;
    mem_we = 1'b0;
    mem_waddr = pa;
    mem_wdata = rd_data;
    mem_re = 1'b0;
    mem_raddr = pa;
    emit = 1'b0;
    emit_status = ST_OK;
    emit_data = '0;
    emit_last = 1'b1;
    case (cmd.op)
      OP_ENQ: begin
        if (fill == '0) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          tail_next = ring_inc(tail, cap);
        end
        mem_we = 1'b1;
        mem_waddr = tail_next;
        mem_wdata = req_r.value;
        fill_next = fill + FW'(1);
        emit = 1'b1;
      end
      OP_EMIT: begin
        emit = 1'b1;
        emit_status = cmd.status;
      end
      OP_DEQ_RD: begin
        mem_re = 1'b1;
        mem_raddr = head;
      end
      OP_DEQ_DONE: begin
        fill_next = fill - FW'(1);
        if (fill == FW'(1)) begin
          head_next = '0;
          tail_next = '0;
        end else begin
          head_next = ring_inc(head, cap);
        end
        emit = 1'b1;
        emit_data = rd_data;
      end
      OP_REV_START: begin
        pa_next = head;
        pb_next = tail;
        rem_next = fill >> 1;
      end
      OP_RD_A: begin
        mem_re = 1'b1;
        mem_raddr = pa;
      end
      OP_RD_B: begin
        mem_re = 1'b1;
        mem_raddr = pb;
        hold_next = rd_data;
      end
      OP_WR_A: begin
        mem_we = 1'b1;
        mem_waddr = pa;
        mem_wdata = rd_data;
      end
      OP_WR_B: begin
        mem_we = 1'b1;
        mem_waddr = pb;
        mem_wdata = hold;
        pa_next = ring_inc(pa, cap);
        pb_next = ring_dec(pb, cap);
        rem_next = rem - FW'(1);
      end
      OP_DUMP_START: begin
        pa_next = head;
        rem_next = fill;
      end
      OP_DUMP_RD: begin
        mem_re = 1'b1;
        mem_raddr = pa;
      end
      OP_DUMP_EMIT: begin
        emit = 1'b1;
        emit_data = rd_data;
        emit_last = (rem == FW'(1));
        pa_next = ring_inc(pa, cap);
        rem_next = rem - FW'(1);
      end
      default: begin
      end
    endcase
    // A capacity write also empties the queue.
    if (cfg_we) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
      cap_raw <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
      if (cfg_we) begin
        cap_raw <= cfg_wdata;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pa <= pa_next;
    pb <= pb_next;
    rem <= rem_next;
    hold <= hold_next;
    if (cmd.load) begin
      req_r <= req;
    end
    if (emit) begin
      rsp.status <= emit_status;
      rsp.data <= emit_data;
      rsp.count <= CNT_W'(fill_next);
      rsp.head_index <= IDX_W'(head_next);
      rsp.tail_index <= (fill_next == '0) ? '0 : IDX_W'(tail_next);
      rsp.last <= emit_last;
    end
  end

endmodule

// ----- tb/circular_queue_with_reverse_unit_test.sv -----
// Self-checking testbench for circular_queue_with_reverse_unit: directed and random requests,
// an in-bench queue predictor, and field-by-field checking of every result item.
// Depends on cqr_pkg and the circular_queue_with_reverse_unit RTL only.
`timescale 1ns / 100ps

module circular_queue_with_reverse_unit_test;
  import cqr_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  // The watchdog limit lies far above the slowest legal run. That run has every request
  // dumping a full ring, every result item stalled, and the long hold-off.
  localparam int CYCLE_LIMIT = 400000;
  // The longest request is a dump or reverse of a full ring.
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Register port.
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Request and result channels.
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  circular_queue_with_reverse_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mirror of the queue. It is updated whenever the block accepts a request item
  // and whenever the capacity register is written.
  logic signed [DATA_W-1:0] ring_words [RING_DEPTH];
  int unsigned              ring_head = 0;
  int unsigned              ring_tail = 0;
  int unsigned              ring_fill = 0;
  logic [CAP_W-1:0]         cap_field = CAP_RESET;

  req_item_t requests_to_send[$];
  rsp_item_t awaited_results[$];

  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_dump_items = 0;
  int n_cap_writes = 0;

  // Sender burst shaping and receiver stall pattern state.
  int          burst_left = 8;
  int          gap_left = 0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          stall_on = 1'b0;
  logic        long_hold_wanted = 1'b0;
  bit          long_hold_done = 1'b0;

  // Queues one result item as the block should report it. Count and positions
  // are taken from the mirror after the request has been applied. The tail
  // position reads zero whenever the queue is empty.
  function automatic void record_result(status_e st, logic signed [DATA_W-1:0] d, bit fin);
    rsp_item_t r;
    r.status     = st;
    r.data       = d;
    r.count      = CNT_W'(ring_fill);
    r.head_index = IDX_W'(ring_head);
    r.tail_index = (ring_fill == 0) ? '0 : IDX_W'(ring_tail);
    r.last       = fin;
    awaited_results.push_back(r);
    if (st == ST_FULL) n_full++;
    if (st == ST_EMPTY) n_empty++;
  endfunction

  // Applies one accepted request to the mirror and records every result item
  // that it causes.
  function automatic void apply_request(req_item_t r);
    int unsigned cap;
    int unsigned a;
    int unsigned b;
    logic signed [DATA_W-1:0] held;
    // A register value of zero acts as one slot, and values above the built
    // depth act as the full depth.
    cap = (cap_field == 0) ? 1 : ((cap_field > RING_DEPTH) ? RING_DEPTH : cap_field);
    n_requests++;
    case (r.req_type)
      REQ_ENQ: begin
        if (ring_fill >= cap) begin
          record_result(ST_FULL, '0, 1'b1);
        end else begin
          if (ring_fill == 0) begin
            ring_head = 0;
            ring_tail = 0;
          end else begin
            ring_tail = (ring_tail + 1) % cap;
          end
          ring_words[ring_tail] = r.value;
          ring_fill++;
          record_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_DEQ: begin
        if (ring_fill == 0) begin
          record_result(ST_EMPTY, '0, 1'b1);
        end else begin
          held = ring_words[ring_head];
          ring_fill--;
          // Taking the final entry sends both positions back to slot zero.
          if (ring_fill == 0) begin
            ring_head = 0;
            ring_tail = 0;
          end else begin
            ring_head = (ring_head + 1) % cap;
          end
          record_result(ST_OK, held, 1'b1);
        end
      end
      REQ_REV: begin
        // Swap pairs from both ends inward. Empty and single-entry queues are
        // left as they are, but still answer with one item.
        for (int unsigned i = 0; i < ring_fill / 2; i++) begin
          a = (ring_head + i) % cap;
          b = (ring_tail + cap - i) % cap;
          held = ring_words[a];
          ring_words[a] = ring_words[b];
          ring_words[b] = held;
        end
        record_result(ST_OK, '0, 1'b1);
      end
      default: begin
        if (ring_fill == 0) begin
          record_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < ring_fill; i++) begin
            a = (ring_head + i) % cap;
            record_result(ST_OK, ring_words[a], (i + 1) == ring_fill);
            n_dump_items++;
          end
        end
      end
    endcase
  endfunction

  // The sender works through requests_to_send in bursts, with idle gaps in between.
  // An item that is offered stays unchanged until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        apply_request(req);
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (requests_to_send.size() > 0) begin
          req <= requests_to_send.pop_front();
          req_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // Gaps of zero keep some back-to-back stretches. Now and then a long burst runs.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver alternates short stall runs with free runs, and some free
  // runs are long. One long hold-off is started on request, and this process
  // counts it out. Meanwhile the sender keeps offering items and the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (long_hold_wanted && !long_hold_done) begin
        hold_left = 300;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (run_left <= 0) begin
          stall_on = !stall_on;
          if (stall_on) begin
            run_left = $urandom_range(1, 5);
          end else begin
            run_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
          end
        end
        run_left--;
        rsp_stall <= stall_on;
      end
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("result field %s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Each accepted result item is checked against the oldest expected item.
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        $error("result item with nothing expected: 0x%0h", rsp);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
        check_field("data", want.data, rsp.data);
        check_field("count", DATA_W'(want.count), DATA_W'(rsp.count));
        check_field("head_index", DATA_W'(want.head_index), DATA_W'(rsp.head_index));
        check_field("tail_index", DATA_W'(want.tail_index), DATA_W'(rsp.tail_index));
        check_field("last", DATA_W'(want.last), DATA_W'(rsp.last));
      end
    end
  end

  // Watchdog. The run fails if it has not finished by the cycle limit.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d result items still awaited",
             cycles, awaited_results.size());
    $display("FAIL circular_queue_with_reverse_unit");
    $finish;
  end

  task automatic add_request(req_e kind, logic [DATA_W-1:0] v);
    req_item_t r;
    r.req_type = kind;
    r.value    = v;
    requests_to_send.push_back(r);
  endtask

  // Holds until every queued item has been sent and answered. It then waits out
  // the block's longest request so that the block is idle.
  task automatic wait_drained();
    do @(posedge clk);
    while (requests_to_send.size() > 0 || req_valid || awaited_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the capacity register, with a setup phase and then an access phase.
  // Random upper bits in pwdata check that only the low field is taken. The
  // write also empties the queue, so the mirror is cleared.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    logic [PDATA_W-1:0] word;
    word = $urandom();
    word[CAP_W-1:0] = v;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CAP_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_field = v;
    ring_head = 0;
    ring_tail = 0;
    ring_fill = 0;
    n_cap_writes++;
  endtask

  // A random phase first leans toward enqueue so that the ring fills and wraps.
  // It then leans toward dequeue so that the ring drains and empties.
  // Reverse and dump items are mixed in throughout.
  task automatic add_random_phase(int n);
    int roll;
    int enq_pct;
    req_e kind;
    for (int i = 0; i < n; i++) begin
      enq_pct = (i < (n * 11) / 20) ? 90 : 25;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        kind = REQ_REV;
      end else if (roll < 16) begin
        kind = REQ_DUMP;
      end else if ($urandom_range(0, 99) < enq_pct) begin
        kind = REQ_ENQ;
      end else begin
        kind = REQ_DEQ;
      end
      add_request(kind, $urandom());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [9];
    phase_caps = '{5'd3, 5'd0, 5'd16, 5'd31, 5'd7, 5'd2, 5'd17, 5'd12, 5'd1};
    for (int i = 0; i < RING_DEPTH; i++) ring_words[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity. Empty-queue requests come first:
    // dequeue and dump report empty, and reverse still answers once.
    add_request(REQ_DEQ, 32'h0000_0000);
    add_request(REQ_DUMP, 32'hFFFF_FFFF);
    add_request(REQ_REV, 32'h0000_0000);
    // Next come a single entry, its reverse and its dump. Dequeuing it returns
    // both positions to slot zero.
    add_request(REQ_ENQ, 32'h7FFF_FFFF);
    add_request(REQ_REV, 32'h0000_0000);
    add_request(REQ_DUMP, 32'h0000_0000);
    add_request(REQ_DEQ, 32'h0000_0000);
    // The extremes of the value field follow, with an even and then an odd
    // reverse.
    add_request(REQ_ENQ, 32'h8000_0000);
    add_request(REQ_ENQ, 32'h0000_0000);
    add_request(REQ_ENQ, 32'hFFFF_FFFF);
    add_request(REQ_ENQ, 32'h0000_0001);
    add_request(REQ_REV, 32'h0000_0000);
    add_request(REQ_DUMP, 32'h0000_0000);
    add_request(REQ_DEQ, 32'h0000_0000);
    add_request(REQ_REV, 32'h0000_0000);
    add_request(REQ_DUMP, 32'h0000_0000);
    wait_drained();

    // A register value of zero gives one usable slot, so the second enqueue is
    // rejected as full.
    write_capacity(5'd0);
    add_request(REQ_ENQ, 32'h1234_5678);
    add_request(REQ_ENQ, 32'h5555_AAAA);
    add_request(REQ_DEQ, 32'h0000_0000);
    add_request(REQ_DEQ, 32'h0000_0000);
    wait_drained();

    // Two slots. The tail wraps to slot zero while the head sits at slot one.
    write_capacity(5'd2);
    add_request(REQ_ENQ, 32'hA5A5_A5A5);
    add_request(REQ_ENQ, 32'h5A5A_5A5A);
    add_request(REQ_ENQ, 32'hDEAD_BEEF);
    add_request(REQ_DEQ, 32'h0000_0000);
    add_request(REQ_ENQ, 32'hC0FF_EE00);
    add_request(REQ_REV, 32'h0000_0000);
    add_request(REQ_DUMP, 32'h0000_0000);
    add_request(REQ_DEQ, 32'h0000_0000);
    add_request(REQ_DEQ, 32'h0000_0000);
    wait_drained();

    // Random phases, one per capacity setting. The queue is drained before
    // every register write. In the phase that writes 16, the receiver holds
    // off for a long stretch, and the block backs up against the sender.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      if (phase_caps[p] == 5'd16) long_hold_wanted <= 1'b1;
      add_random_phase(45);
      wait_drained();
    end

    $display("covered %0d requests and %0d result items (%0d dumped entries) over %0d capacity writes",
             n_requests, n_results, n_dump_items, n_cap_writes);
    $display("full rejections %0d, empty outcomes %0d, mismatches %0d", n_full, n_empty, errors);
    if (errors == 0) begin
      $display("PASS circular_queue_with_reverse_unit");
    end else begin
      $display("FAIL circular_queue_with_reverse_unit");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cqr_pkg.sv
design/cqr_ctrl.sv
design/cqr_dp.sv
design/circular_queue_with_reverse_unit.sv
tb/circular_queue_with_reverse_unit_test.sv
